@@ design/spe_pkg.sv @@
// Shared constants and types for the sparse polynomial evaluator.
package spe_pkg;

    localparam int unsigned EXP_BITS = 16;
    localparam int unsigned EXPO_W   = 16;
    localparam int unsigned Q_W      = 32;

    localparam logic [Q_W-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [Q_W-1:0] Q_ZERO = 32'h0000_0000;
    localparam logic [Q_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN  = 32'h8000_0000;

    localparam logic [EXPO_W-1:0] GAP_MASK = (EXP_BITS >= EXPO_W) ? {EXPO_W{1'b1}} :
        EXPO_W'((33'd1 << EXP_BITS) - 33'd1);

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           sat;
    } t_qres;

endpackage

@@ design/spe_qmul.sv @@
// Shared Q16.16 multiplier: registered product, then truncate and saturate.
module spe_qmul
    import spe_pkg::*;
(
    input  logic                  i_clk,
    input  logic signed [Q_W-1:0] i_a,
    input  logic signed [Q_W-1:0] i_b,
    output t_qres                 o_res
);

    logic signed [2*Q_W-1:0] r_prod;
    logic signed [2*Q_W-1:0] adj;
    logic                    in_range;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // round toward zero: bias negatives before the arithmetic shift
    assign adj = r_prod + (r_prod[2*Q_W-1] ? 64'sh0000_0000_0000_FFFF : 64'sh0);
    assign in_range = (&adj[2*Q_W-1:47]) || !(|adj[2*Q_W-1:47]);

    always_comb begin
        if (in_range) begin
            o_res.q   = adj[47:16];
            o_res.sat = 1'b0;
        end else begin
            o_res.q   = adj[2*Q_W-1] ? Q_MIN : Q_MAX;
            o_res.sat = 1'b1;
        end
    end

endmodule

@@ design/sparse_polynomial_evaluator_core.sv @@
// Sparse polynomial evaluator top level: term sequencer around one shared multiplier.
//
//  channel  direction  handshake                  payload
//  term     in         i_in_valid / o_in_stall    first_term x_value exponent coefficient last_term
//  result   out        o_out_valid / i_out_stall  poly_value overflow order_error
//
// A term takes M multiplies on the shared multiplier, M = set bits of the gap plus the index of
// its top set bit (square-and-multiply), then the power and term multiplies and the saturating add.
// A skipped term goes straight to the emit. One term is worked on at a time.
// Reset clears control and state; the held result is lost.
// A stalled result holds; the next term is accepted meanwhile, and its result waits.
module sparse_polynomial_evaluator_core
    import spe_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_first_term,
    input  logic signed [Q_W-1:0]    i_x_value,
    input  logic [EXPO_W-1:0]        i_exponent,
    input  logic signed [Q_W-1:0]    i_coefficient,
    input  logic                     i_last_term,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [Q_W-1:0]    o_poly_value,
    output logic                     o_overflow,
    output logic                     o_order_error
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_WB   = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    typedef enum logic [4:0] {
        OP_FAC  = 5'b00001,
        OP_SQR  = 5'b00010,
        OP_POW  = 5'b00100,
        OP_TERM = 5'b01000,
        OP_ADD  = 5'b10000
    } t_op;

    function automatic t_op pick_op(input logic [EXPO_W-1:0] g);
        t_op op;
        if (g == '0) begin
            op = OP_POW;
        end else if (g[0]) begin
            op = OP_FAC;
        end else begin
            op = OP_SQR;
        end
        return op;
    endfunction

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [Q_W-1:0]    r_x, n_x;
    logic [Q_W-1:0]    r_power, n_power;
    logic [Q_W-1:0]    r_sum, n_sum;
    logic [Q_W-1:0]    r_base, n_base;
    logic [Q_W-1:0]    r_fac, n_fac;
    logic [Q_W-1:0]    r_term, n_term;
    logic [Q_W-1:0]    r_coef, n_coef;
    logic [EXPO_W-1:0] r_prev, n_prev;
    logic [EXPO_W-1:0] r_gap, n_gap;
    logic              r_ovf, n_ovf;
    logic              r_ord, n_ord;
    logic              r_last, n_last;

    logic              r_out_valid, n_out_valid;
    logic [Q_W-1:0]    r_out_value, n_out_value;
    logic              r_out_ovf, n_out_ovf;
    logic              r_out_ord, n_out_ord;

    logic signed [Q_W-1:0] mul_a, mul_b;
    t_qres                 mul_res;
    logic [EXPO_W-1:0]     acc_prev, acc_gap;
    logic [Q_W:0]          add_full;
    logic                  in_accept;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        case (r_op)
            OP_FAC:  begin mul_a = r_fac;   mul_b = r_base; end
            OP_SQR:  begin mul_a = r_base;  mul_b = r_base; end
            OP_POW:  begin mul_a = r_power; mul_b = r_fac;  end
            OP_TERM: begin mul_a = r_power; mul_b = r_coef; end
            default: begin mul_a = r_power; mul_b = r_coef; end
        endcase
    end

    spe_qmul u_qmul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_res (mul_res)
    );

    assign acc_prev = i_first_term ? '0 : r_prev;
    assign acc_gap  = (i_exponent - acc_prev) & GAP_MASK;
    assign add_full = {r_sum[Q_W-1], r_sum} + {r_term[Q_W-1], r_term};

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_x         = r_x;
        n_power     = r_power;
        n_sum       = r_sum;
        n_base      = r_base;
        n_fac       = r_fac;
        n_term      = r_term;
        n_coef      = r_coef;
        n_prev      = r_prev;
        n_gap       = r_gap;
        n_ovf       = r_ovf;
        n_ord       = r_ord;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_value = r_out_value;
        n_out_ovf   = r_out_ovf;
        n_out_ord   = r_out_ord;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_last = i_last_term;
                    n_coef = i_coefficient;
                    if (i_first_term) begin
                        n_x     = i_x_value;
                        n_power = Q_ONE;
                        n_sum   = Q_ZERO;
                        n_ovf   = 1'b0;
                        n_ord   = 1'b0;
                    end
                    if (!i_first_term && (i_exponent <= r_prev)) begin
                        n_ord   = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_prev  = i_exponent;
                        n_gap   = acc_gap;
                        n_base  = i_first_term ? i_x_value : r_x;
                        n_fac   = Q_ONE;
                        n_op    = pick_op(acc_gap);
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_state = S_WB;
            end
            S_WB: begin
                n_state = S_MUL;
                if (r_op != OP_ADD) begin
                    n_ovf = r_ovf | mul_res.sat;
                end
                case (r_op)
                    OP_FAC: begin
                        n_fac = mul_res.q;
                        if (r_gap[EXPO_W-1:1] != '0) begin
                            n_op = OP_SQR;
                        end else begin
                            n_gap = '0;
                            n_op  = OP_POW;
                        end
                    end
                    OP_SQR: begin
                        n_base = mul_res.q;
                        n_gap  = r_gap >> 1;
                        n_op   = pick_op(r_gap >> 1);
                    end
                    OP_POW: begin
                        n_power = mul_res.q;
                        n_op    = OP_TERM;
                    end
                    OP_TERM: begin
                        n_term  = mul_res.q;
                        n_op    = OP_ADD;
                        n_state = S_WB;
                    end
                    OP_ADD: begin
                        if (add_full[Q_W] != add_full[Q_W-1]) begin
                            n_sum = add_full[Q_W] ? Q_MIN : Q_MAX;
                            n_ovf = 1'b1;
                        end else begin
                            n_sum = add_full[Q_W-1:0];
                        end
                        n_state = S_EMIT;
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_EMIT: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_sum;
                    n_out_ovf   = r_ovf;
                    n_out_ord   = r_ord;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_POW;
            r_x         <= Q_ZERO;
            r_power     <= Q_ONE;
            r_sum       <= Q_ZERO;
            r_prev      <= '0;
            r_ovf       <= 1'b0;
            r_ord       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_x         <= n_x;
            r_power     <= n_power;
            r_sum       <= n_sum;
            r_prev      <= n_prev;
            r_ovf       <= n_ovf;
            r_ord       <= n_ord;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_fac       <= n_fac;
        r_term      <= n_term;
        r_coef      <= n_coef;
        r_gap       <= n_gap;
        r_last      <= n_last;
        r_out_value <= n_out_value;
        r_out_ovf   <= n_out_ovf;
        r_out_ord   <= n_out_ord;
    end

    assign o_out_valid   = r_out_valid;
    assign o_poly_value  = r_out_value;
    assign o_overflow    = r_out_ovf;
    assign o_order_error = r_out_ord;

    a_mul_then_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_WB))
        else $error("multiply issue not followed by writeback");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("accepted beat did not start work");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || !i_out_stall) && !(r_state == S_EMIT && r_last) |=> !r_out_valid)
        else $error("result appeared without an emit");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf && !(in_accept && i_first_term) |=> r_ovf)
        else $error("overflow flag dropped inside an evaluation");

    a_gap_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> ((r_gap & ~GAP_MASK) == '0))
        else $error("gap holds bits beyond the exponent range");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the sparse polynomial evaluator core.
module testbench
    import spe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 100;
    localparam int unsigned RANDOM_TERMS   = 1325;
    localparam longint     SAT_HI          = 64'sh0000_0000_7FFF_FFFF;
    localparam longint     SAT_LO          = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic              first;
        logic [Q_W-1:0]    x;
        logic [EXPO_W-1:0] expo;
        logic [Q_W-1:0]    coef;
        logic              last;
    } t_term;

    typedef struct packed {
        logic [Q_W-1:0] value;
        logic           ovf;
        logic           order;
    } t_poly_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_first_term;
    logic signed [Q_W-1:0] i_x_value;
    logic [EXPO_W-1:0]     i_exponent;
    logic signed [Q_W-1:0] i_coefficient;
    logic                  i_last_term;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic signed [Q_W-1:0] o_poly_value;
    logic                  o_overflow;
    logic                  o_order_error;

    // evaluator state mirror
    logic signed [Q_W-1:0] ev_x;
    logic signed [Q_W-1:0] ev_power;
    logic signed [Q_W-1:0] ev_sum;
    logic [EXPO_W-1:0]     ev_prev;
    bit                    ev_ovf;
    bit                    ev_order;

    t_poly_result poly_results_q[$];
    t_poly_result want;

    bit          idle_on;
    bit          hold_drawn;
    int unsigned out_hold;
    int unsigned quiet_cycles;
    int unsigned errors;
    int unsigned terms_sent;
    int unsigned sums_checked;
    int unsigned sums_ovf;
    int unsigned sums_order;

    sparse_polynomial_evaluator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_first_term  (i_first_term),
        .i_x_value     (i_x_value),
        .i_exponent    (i_exponent),
        .i_coefficient (i_coefficient),
        .i_last_term   (i_last_term),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_poly_value  (o_poly_value),
        .o_overflow    (o_overflow),
        .o_order_error (o_order_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [Q_W-1:0] clamp_q(longint v);
        if (v > SAT_HI) begin
            ev_ovf = 1'b1;
            return Q_MAX;
        end
        if (v < SAT_LO) begin
            ev_ovf = 1'b1;
            return Q_MIN;
        end
        return v[Q_W-1:0];
    endfunction

    // full product, >> 16 truncating toward zero, saturated
    function automatic logic signed [Q_W-1:0] mul_q(logic signed [Q_W-1:0] a,
                                                    logic signed [Q_W-1:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        p = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
        return clamp_q(p);
    endfunction

    function automatic logic signed [Q_W-1:0] raise_q(logic signed [Q_W-1:0] base,
                                                      logic [EXPO_W-1:0] gap);
        logic signed [Q_W-1:0] factor;
        logic signed [Q_W-1:0] sq;
        logic [EXPO_W-1:0]     g;
        factor = Q_ONE;
        sq     = base;
        g      = gap & GAP_MASK;
        for (int j = 0; j < EXP_BITS && j < 32; j++) begin
            if (((g >> j) & 1) != 0)
                factor = mul_q(factor, sq);
            if ((g >> (j + 1)) != 0)
                sq = mul_q(sq, sq);
        end
        return factor;
    endfunction

    function automatic void predict_term(t_term t);
        bit                    skip;
        logic signed [Q_W-1:0] factor;
        logic signed [Q_W-1:0] part;
        skip = 1'b0;
        if (t.first) begin
            ev_x     = t.x;
            ev_power = Q_ONE;
            ev_sum   = Q_ZERO;
            ev_prev  = '0;
            ev_ovf   = 1'b0;
            ev_order = 1'b0;
        end else if (t.expo <= ev_prev) begin
            ev_order = 1'b1;
            skip     = 1'b1;
        end
        if (!skip) begin
            factor   = raise_q(ev_x, t.expo - ev_prev);
            ev_power = mul_q(ev_power, factor);
            part     = mul_q(ev_power, t.coef);
            ev_sum   = clamp_q(longint'(ev_sum) + longint'(part));
            ev_prev  = t.expo;
        end
        if (t.last)
            poly_results_q.push_back({ev_sum, ev_ovf, ev_order});
    endfunction

    function automatic logic [Q_W-1:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return Q_ONE;
                    3: return -Q_ONE;
                    default: return Q_ZERO;
                endcase
            end
            default: return Q_W'(int'($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
        endcase
    endfunction

    // entered and left at a falling edge; valid stays high for back-to-back beats
    task automatic send_term(input t_term t);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_first_term  = t.first;
        i_x_value     = t.x;
        i_exponent    = t.expo;
        i_coefficient = t.coef;
        i_last_term   = t.last;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_term(t);
        terms_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (poly_results_q.size() != 0)
            @(negedge i_clk);
    endtask

    // terms with no start since reset work on x = 0, and sums carry on after a result
    task automatic test_no_start();
        send_term({1'b0, 32'h1234_5678, 16'd3, Q_ONE, 1'b1});
        send_term({1'b0, 32'hFFFF_FFFF, 16'd5, 32'h0003_0000, 1'b1});
        send_term({1'b0, 32'h0000_0000, 16'd5, Q_ONE, 1'b1});
    endtask

    task automatic test_basic_sums();
        send_term({1'b1, 32'h0002_0000, 16'd0, 32'h0001_8000, 1'b1});
        send_term({1'b1, 32'h0001_8000, 16'd1, 32'h0002_0000, 1'b0});
        send_term({1'b0, 32'hDEAD_BEEF, 16'd3, 32'hFFFF_0000, 1'b0});
        send_term({1'b0, 32'h0000_0000, 16'd7, 32'h0000_4000, 1'b1});
        send_term({1'b0, 32'h7FFF_FFFF, 16'd8, Q_ONE, 1'b1});
    endtask

    task automatic test_extremes();
        send_term({1'b1, Q_MAX, 16'hFFFF, Q_MIN, 1'b1});
        send_term({1'b1, Q_MIN, 16'd1, Q_MAX, 1'b1});
        send_term({1'b1, 32'hFFFE_8000, 16'd2, Q_ONE, 1'b0});
        send_term({1'b0, 32'h0000_0000, 16'd3, 32'h0000_0001, 1'b1});
        send_term({1'b1, 32'h0000_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1});
        send_term({1'b1, Q_ZERO, 16'd0, Q_ZERO, 1'b1});
        send_term({1'b1, 32'h0002_0000, 16'h8000, Q_ONE, 1'b1});
        send_term({1'b1, 32'h0002_0000, 16'd14, Q_ONE, 1'b1});
        send_term({1'b1, 32'hFFFE_0000, 16'd15, 32'h0000_0002, 1'b1});
    endtask

    task automatic test_order_errors();
        send_term({1'b1, Q_ONE, 16'd5, Q_ONE, 1'b0});
        send_term({1'b0, 32'h5555_5555, 16'd5, Q_ONE, 1'b0});
        send_term({1'b0, 32'hAAAA_AAAA, 16'd2, Q_ONE, 1'b0});
        send_term({1'b0, 32'h0000_0000, 16'd6, Q_ONE, 1'b1});
        send_term({1'b1, Q_ONE, 16'd0, Q_ONE, 1'b0});
        send_term({1'b0, Q_ONE, 16'd0, Q_ONE, 1'b1});
        send_term({1'b1, Q_ONE, 16'd3, Q_ONE, 1'b1});
    endtask

    task automatic test_random_polys(input int unsigned n_terms);
        int unsigned target;
        int unsigned count;
        int          expo;
        t_term       t;
        target = terms_sent + n_terms;
        while (terms_sent < target) begin
            idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 39) == 0)
                drain_results();
            if ($urandom_range(0, 9) < 8) begin
                count = $urandom_range(1, 6);
                expo  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 3);
                for (int k = 0; k < count; k++) begin
                    t.first = (k == 0);
                    t.x     = (k == 0) ? rand_q() : Q_W'($urandom);
                    t.expo  = EXPO_W'(expo);
                    t.coef  = rand_q();
                    t.last  = (k == count - 1);
                    send_term(t);
                    expo += ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40000)
                                                        : $urandom_range(1, 6);
                    if (expo > 65535)
                        expo = 65535;
                end
            end else begin
                count = $urandom_range(1, 4);
                for (int k = 0; k < count; k++) begin
                    t.first = ($urandom_range(0, 3) == 0);
                    t.x     = $urandom;
                    t.expo  = $urandom_range(0, 1) ? EXPO_W'($urandom_range(0, 65535))
                                                   : EXPO_W'($urandom_range(0, 8));
                    t.coef  = rand_q();
                    t.last  = 1'($urandom_range(0, 1));
                    send_term(t);
                end
            end
        end
    endtask

    // result side: random stall per beat, and stray stalls while nothing is offered
    always @(negedge i_clk) begin
        if (!o_out_valid) begin
            i_out_stall = idle_on && ($urandom_range(0, 3) == 0);
            hold_drawn  = 1'b0;
        end else begin
            if (!hold_drawn) begin
                out_hold   = idle_on ? $urandom_range(0, 3) : 0;
                hold_drawn = 1'b1;
            end
            if (out_hold > 0) begin
                i_out_stall = 1'b1;
                out_hold--;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            hold_drawn = 1'b0;
            sums_checked++;
            if (o_overflow)
                sums_ovf++;
            if (o_order_error)
                sums_order++;
            if (poly_results_q.size() == 0) begin
                $display("%0t: unexpected result beat value %h ovf %b order %b",
                         $time, o_poly_value, o_overflow, o_order_error);
                errors++;
            end else begin
                want = poly_results_q.pop_front();
                if (o_poly_value !== want.value) begin
                    $display("%0t: poly_value expected %h actual %h",
                             $time, want.value, o_poly_value);
                    errors++;
                end
                if (o_overflow !== want.ovf) begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, want.ovf, o_overflow);
                    errors++;
                end
                if (o_order_error !== want.order) begin
                    $display("%0t: order_error expected %b actual %b",
                             $time, want.order, o_order_error);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_first_term  = 1'b0;
        i_x_value     = '0;
        i_exponent    = '0;
        i_coefficient = '0;
        i_last_term   = 1'b0;
        i_out_stall   = 1'b0;
        idle_on       = 1'b1;
        hold_drawn    = 1'b0;
        out_hold      = 0;
        quiet_cycles  = 0;
        errors        = 0;
        terms_sent    = 0;
        sums_checked  = 0;
        sums_ovf      = 0;
        sums_order    = 0;
        ev_x          = Q_ZERO;
        ev_power      = Q_ONE;
        ev_sum        = Q_ZERO;
        ev_prev       = '0;
        ev_ovf        = 1'b0;
        ev_order      = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_no_start();
        idle_on = 1'b0;
        test_basic_sums();
        idle_on = 1'b1;
        test_extremes();
        drain_results();
        test_order_errors();
        test_random_polys(RANDOM_TERMS);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d terms sent, %0d sums checked", terms_sent, sums_checked);
        $display("Summary: %0d sums saturated, %0d sums with skipped terms",
                 sums_ovf, sums_order);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
